FILE: rtl/mfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg: shared types and constants of the frame receiver
// Header characters, field widths and the records passed between the parser,
// the descriptor queue and the readout.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // Header characters of a request frame.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_LT     = 8'h3C;

  // Fixed field widths of the result channel.
  localparam int SIZE_W = 7;
  localparam int BIDX_W = 6;

  // One accepted frame waiting for readout.
  typedef struct packed {
    logic [7:0]        command;
    logic [SIZE_W-1:0] size;
    logic              bank;
  } desc_t;

  // Readout tells the parser that a buffer bank is free again.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // One result as held in the output queue.
  typedef struct packed {
    logic [7:0]        command;
    logic [SIZE_W-1:0] payload_size;
    logic [BIDX_W-1:0] byte_index;
    logic [7:0]        payload_byte;
    logic              has_payload;
    logic              last;
  } res_t;

endpackage

FILE: rtl/mfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/mfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_front: frame parser
// Hunts for the header, checks the size, stores the payload into a free
// buffer bank and queues a descriptor when the checksum matches.
// ----------------------------------------------------------------------------
module mfr_front
  import mfr_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_rx_byte,
  output logic             ram_wr_en,
  output logic [IDX_W:0]   ram_wr_addr,
  output logic [7:0]       ram_wr_data,
  output logic             dq_push,
  output desc_t            dq_desc,
  input  logic             dq_full,
  input  rel_t             release_i
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DOLLAR = 3'd1,
    PH_M      = 3'd2,
    PH_ARROW  = 3'd3,
    PH_SIZE   = 3'd4,
    PH_BODY   = 3'd5
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] fill_r, fill_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic              body_data;
  logic              accept;
  logic              commit;

  // A payload byte needs a free bank; a checksum byte needs queue space.
  assign body_data = (phase_r == PH_BODY) && (fill_r < size_r);
  assign full      = (phase_r == PH_BODY) && (body_data ? busy_r[bank_r] : dq_full);
  assign accept    = push && !full;

  // Parser next state.
  always_comb begin
    phase_nxt = phase_r;
    size_nxt  = size_r;
    fill_nxt  = fill_r;
    xor_nxt   = xor_r;
    cmd_nxt   = cmd_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    ram_wr_en = 1'b0;
    commit    = 1'b0;
    if (release_i.valid) begin
      busy_nxt[release_i.bank] = 1'b0;
    end
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = (in_rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
        end
        PH_DOLLAR: begin
          phase_nxt = (in_rx_byte == CH_M) ? PH_M : PH_IDLE;
        end
        PH_M: begin
          phase_nxt = (in_rx_byte == CH_LT) ? PH_ARROW : PH_IDLE;
        end
        PH_ARROW: begin
          if (in_rx_byte > 8'(BUF_DEPTH)) begin
            phase_nxt = PH_IDLE;
          end else begin
            size_nxt  = in_rx_byte[SIZE_W-1:0];
            xor_nxt   = in_rx_byte;
            fill_nxt  = '0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          cmd_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          if (body_data) begin
            xor_nxt   = xor_r ^ in_rx_byte;
            ram_wr_en = 1'b1;
            fill_nxt  = fill_r + 1'b1;
          end else begin
            if (xor_r == in_rx_byte) begin
              commit = 1'b1;
              // A frame with payload hands its bank over to the readout.
              if (size_r != '0) begin
                busy_nxt[bank_r] = 1'b1;
                bank_nxt         = !bank_r;
              end
            end
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
        end
      endcase
    end
  end

  assign ram_wr_addr      = {bank_r, fill_r[IDX_W-1:0]};
  assign ram_wr_data      = in_rx_byte;
  assign dq_push          = commit;
  assign dq_desc.command  = cmd_r;
  assign dq_desc.size     = size_r;
  assign dq_desc.bank     = bank_r;

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
    size_r <= size_nxt;
    fill_r <= fill_nxt;
    xor_r  <= xor_nxt;
    cmd_r  <= cmd_nxt;
  end

endmodule

FILE: rtl/mfr_desc_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_desc_q: descriptor queue
// Two-entry queue of accepted frames between the parser and the readout.
// ----------------------------------------------------------------------------
module mfr_desc_q
  import mfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t      ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  // Queue registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

endmodule

FILE: rtl/mfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_back: frame readout
// Walks one queued frame at a time through its buffer bank and delivers one
// result per payload byte (one if empty) through a four-entry output queue.
// ----------------------------------------------------------------------------
module mfr_back
  import mfr_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                dq_empty,
  input  desc_t               dq_head,
  output logic                dq_pop,
  output logic                ram_rd_en,
  output logic [IDX_W:0]      ram_rd_addr,
  input  logic [7:0]          ram_rd_data,
  output rel_t                release_o,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_command,
  output logic [SIZE_W-1:0]   out_payload_size,
  output logic [BIDX_W-1:0]   out_byte_index,
  output logic [7:0]          out_payload_byte,
  output logic                out_has_payload,
  output logic                out_last
);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);

  logic              active_r, active_nxt;
  desc_t             cur_r, cur_nxt;
  logic [SIZE_W-1:0] idx_r, idx_nxt;
  logic              infl_r, infl_nxt;
  res_t              meta_r, meta_nxt;
  res_t              oq_r [OQ_DEPTH];
  res_t              oq_in;
  res_t              oq_head;
  logic [OQ_PW-1:0]  wptr_r, rptr_r;
  logic [OQ_PW:0]    cnt_r, cnt_nxt;
  logic              credit;
  logic              issue;
  logic              is_last;
  logic              do_pop;

  // Room for one more read counts results already in flight.
  assign credit  = ({1'b0, cnt_r} + {{(OQ_PW+1){1'b0}}, infl_r}) < (OQ_PW + 2)'(OQ_DEPTH);
  assign issue   = active_r && credit;
  assign is_last = (cur_r.size == '0) || ((idx_r + 1'b1) == cur_r.size);
  assign dq_pop  = !active_r && !dq_empty;
  assign do_pop  = pop && !empty;

  // Readout sequencer.
  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    meta_nxt   = meta_r;
    infl_nxt   = issue;
    release_o  = '{valid: 1'b0, bank: cur_r.bank};
    if (dq_pop) begin
      active_nxt = 1'b1;
      cur_nxt    = dq_head;
      idx_nxt    = '0;
    end else if (issue) begin
      meta_nxt.command      = cur_r.command;
      meta_nxt.payload_size = cur_r.size;
      meta_nxt.byte_index   = idx_r[BIDX_W-1:0];
      meta_nxt.payload_byte = '0;
      meta_nxt.has_payload  = (cur_r.size != '0);
      meta_nxt.last         = is_last;
      idx_nxt               = idx_r + 1'b1;
      if (is_last) begin
        active_nxt      = 1'b0;
        release_o.valid = (cur_r.size != '0);
      end
    end
  end

  assign ram_rd_en   = issue;
  assign ram_rd_addr = {cur_r.bank, idx_r[IDX_W-1:0]};

  // Read data joins its result fields in the cycle after the read.
  always_comb begin
    oq_in = meta_r;
    if (meta_r.has_payload) begin
      oq_in.payload_byte = ram_rd_data;
    end
    cnt_nxt = cnt_r + {{OQ_PW{1'b0}}, infl_r} - {{OQ_PW{1'b0}}, do_pop};
  end

  // Sequencer and output queue registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      infl_r   <= 1'b0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      infl_r   <= infl_nxt;
      cnt_r    <= cnt_nxt;
      if (infl_r) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    meta_r <= meta_nxt;
    if (infl_r) begin
      oq_r[wptr_r] <= oq_in;
    end
  end

  assign empty            = (cnt_r == '0);
  assign oq_head          = oq_r[rptr_r];
  assign out_command      = oq_head.command;
  assign out_payload_size = oq_head.payload_size;
  assign out_byte_index   = oq_head.byte_index;
  assign out_payload_byte = oq_head.payload_byte;
  assign out_has_payload  = oq_head.has_payload;
  assign out_last         = oq_head.last;

endmodule

FILE: rtl/msp_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_frame_receiver: request frame receiver
// Parses '$' 'M' '<' size command payload checksum frames from a byte stream
// and delivers each good frame as one result per payload byte (one if empty).
//
//   channel   handshake     payload
//   input     push / full   in_rx_byte
//   result    pop / empty   out_command, out_payload_size, out_byte_index,
//                           out_payload_byte, out_has_payload, out_last
//
// The parser takes one byte per cycle. Payload goes into one of two buffer
// banks; a payload byte stalls while its bank still holds a frame not yet
// read out, and a checksum byte stalls while the two-entry descriptor queue
// is full. Readout delivers one result per cycle while its output queue has
// room, and takes up the next frame only once the last read of the one
// before has been issued. Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module msp_frame_receiver
  import mfr_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_rx_byte,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_command,
  output logic [SIZE_W-1:0] out_payload_size,
  output logic [BIDX_W-1:0] out_byte_index,
  output logic [7:0]        out_payload_byte,
  output logic              out_has_payload,
  output logic              out_last
);

  localparam int IDX_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int RAM_DEPTH = 2 << IDX_W;

  logic           ram_wr_en;
  logic [IDX_W:0] ram_wr_addr;
  logic [7:0]     ram_wr_data;
  logic           ram_rd_en;
  logic [IDX_W:0] ram_rd_addr;
  logic [7:0]     ram_rd_data;
  logic           dq_push;
  desc_t          dq_desc;
  logic           dq_full;
  logic           dq_pop;
  desc_t          dq_head;
  logic           dq_empty;
  rel_t           bank_rel;

  // Parser.
  mfr_front #(
    .BUF_DEPTH(BUF_DEPTH),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .dq_push    (dq_push),
    .dq_desc    (dq_desc),
    .dq_full    (dq_full),
    .release_i  (bank_rel)
  );

  // Two-bank payload buffer.
  mfr_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Accepted frames waiting for readout.
  mfr_desc_q u_desc_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (dq_push),
    .push_desc(dq_desc),
    .full     (dq_full),
    .pop      (dq_pop),
    .head     (dq_head),
    .empty    (dq_empty)
  );

  // Readout.
  mfr_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dq_empty        (dq_empty),
    .dq_head         (dq_head),
    .dq_pop          (dq_pop),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .release_o       (bank_rel),
    .empty           (empty),
    .pop             (pop),
    .out_command     (out_command),
    .out_payload_size(out_payload_size),
    .out_byte_index  (out_byte_index),
    .out_payload_byte(out_payload_byte),
    .out_has_payload (out_has_payload),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/mfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_checker: port-level checks of the frame receiver
// Watches the result channel for consistency of the delivered fields.
// ----------------------------------------------------------------------------
module mfr_checker
  import mfr_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              empty,
  input logic              pop,
  input logic [7:0]        out_command,
  input logic [SIZE_W-1:0] out_payload_size,
  input logic [BIDX_W-1:0] out_byte_index,
  input logic [7:0]        out_payload_byte,
  input logic              out_has_payload,
  input logic              out_last
);

  // Nothing is offered right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> empty)
    else $error("result offered right after reset");

  // An empty frame is a single result with zero size, index and byte.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_payload) |->
      (out_payload_size == '0 && out_byte_index == '0 &&
       out_payload_byte == '0 && out_last))
    else $error("malformed empty-frame result");

  // A payload result lies inside its frame and marks the last byte.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_has_payload) |->
      ({1'b0, out_byte_index} < out_payload_size &&
       out_payload_size <= SIZE_W'(BUF_DEPTH) &&
       out_last == (({1'b0, out_byte_index} + 1'b1) == out_payload_size)))
    else $error("payload result outside its frame");

  // Results of one frame come in index order.
  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=>
      (empty || ({1'b0, out_byte_index} == ({1'b0, $past(out_byte_index)} + 1'b1) &&
                 out_command == $past(out_command))))
    else $error("payload results out of order");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=>
      (!empty && $stable(out_command) && $stable(out_byte_index) &&
       $stable(out_payload_byte) && $stable(out_last)))
    else $error("waiting result changed");

endmodule

bind msp_frame_receiver mfr_checker #(
  .BUF_DEPTH(BUF_DEPTH)
) u_mfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_command     (out_command),
  .out_payload_size(out_payload_size),
  .out_byte_index  (out_byte_index),
  .out_payload_byte(out_payload_byte),
  .out_has_payload (out_has_payload),
  .out_last        (out_last)
);
